/* hdl/assert_macros.svh */
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the block clock, off during reset
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, sampled on the block clock, off during reset
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hdl/zhu_pkg.sv */
// shared types, constants and key table of the zobrist hash updater
package zhu_pkg;

   localparam int KEY_COUNT  = 793;
   localparam int KEY_ADDR_W = 10;
   localparam int HASH_W     = 64;

   typedef logic [KEY_ADDR_W-1:0] key_addr_type;
   typedef logic [HASH_W-1:0]     hash_type;
   typedef hash_type              key_array_type [0:KEY_COUNT-1];

   localparam key_addr_type COLOR_STRIDE = key_addr_type'(384);
   localparam key_addr_type CASTLE_BASE  = key_addr_type'(768);
   localparam key_addr_type EP_BASE      = key_addr_type'(784);
   localparam key_addr_type SIDE_KEY     = key_addr_type'(792);

   localparam logic [2:0] PIECE_KIND_COUNT = 3'd6;

   localparam hash_type GEN_SEED     = 64'd49109794719;
   localparam hash_type GEN_ALT_SEED = 64'hDEADBEEFCAFEBABE;
   localparam hash_type GEN_MUL      = 64'h2545F4914F6CDD1D;
   localparam int       SH_A = 12;
   localparam int       SH_B = 25;
   localparam int       SH_C = 27;

   typedef enum logic [2:0] {
      CMD_LOAD      = 3'd0,
      CMD_TOGGLE    = 3'd1,
      CMD_MOVE      = 3'd2,
      CMD_FLIP_SIDE = 3'd3,
      CMD_CASTLING  = 3'd4,
      CMD_EP_FILE   = 3'd5
   } cmd_type;

   // xorshift64* key sequence, evaluated at elaboration only
   function automatic key_array_type build_keys();
      key_array_type keys;
      hash_type      s;
      s = (GEN_SEED != '0) ? GEN_SEED : GEN_ALT_SEED;
      for (int k = 0; k < KEY_COUNT; k++) begin
         s = s ^ (s >> SH_A);
         s = s ^ (s << SH_B);
         s = s ^ (s >> SH_C);
         keys[k] = s * GEN_MUL;
      end
      return keys;
   endfunction

   localparam key_array_type KEY_TABLE = build_keys();

   // piece key address: color * 384 + kind * 64 + square
   function automatic key_addr_type piece_addr(logic color, logic [2:0] kind,
                                               logic [5:0] square);
      return key_addr_type'({kind, square}) + (color ? COLOR_STRIDE : '0);
   endfunction

endpackage

/* hdl/zobrist_hash_updater_core.sv */
// top level of the zobrist hash updater: key rom, hash register, result register
//
// usage
//   req channel: one command word per accepted cycle (valid high, stall low).
//     load, toggle piece, move piece, flip side, toggle castling, toggle ep.
//   rsp channel: one word per request, carrying the hash after that command.
// pipeline
//   an accepted request goes through the registered key rom read, then the xor
//   into the hash register and the result register, before it shows on rsp.
// throughput
//   one word per cycle while rsp is not stalled; the hash register feeds back through a single xor,
//   and the two key rom read ports serve both squares of a move in one go.
// reset
//   synchronous, active high: hash clears to zero, both stages go empty.
// stall
//   rsp_stall with a word waiting freezes both stages and raises req_stall in
//   the same cycle; the waiting word holds until taken. while the result
//   register is empty or draining, a new request is taken every cycle.
module zobrist_hash_updater_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic        req_color,
   input  logic [2:0]  req_piece_kind,
   input  logic [5:0]  req_from_square,
   input  logic [5:0]  req_to_square,
   input  logic [3:0]  req_castling_word,
   input  logic [2:0]  req_ep_file,
   input  logic [63:0] req_load_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_hash
);

   // decoded per-command controls carried with the key reads
   typedef struct packed {
      logic load;   // replace hash with the raw value
      logic use_a;  // xor key from port a
      logic use_b;  // xor key from port b
   } ctrl_type;

   logic                 advance;
   zhu_pkg::cmd_type     cmd;
   logic                 kind_ok;
   zhu_pkg::key_addr_type addr_a;
   zhu_pkg::key_addr_type addr_b;
   ctrl_type             ctrl_in;

   // read stage
   logic                 s1_valid_ff;
   ctrl_type             s1_ctrl_ff;
   zhu_pkg::hash_type    key_a_ff;
   zhu_pkg::hash_type    key_b_ff;
   zhu_pkg::hash_type    load_ff;

   // hash state and result register
   zhu_pkg::hash_type    hash_ff;
   zhu_pkg::hash_type    hash_in;
   logic                 rsp_valid_ff;
   zhu_pkg::hash_type    rsp_hash_ff;

   // both stages move together whenever the result register can take a word
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   assign cmd     = zhu_pkg::cmd_type'(req_command);
   assign kind_ok = req_piece_kind < zhu_pkg::PIECE_KIND_COUNT;

   // command decoder: port a serves the from square, port b everything else
   always_comb begin
      ctrl_in = '0;
      addr_a  = '0;
      addr_b  = '0;
      unique case (cmd)
         zhu_pkg::CMD_LOAD: begin
            ctrl_in.load = 1'b1;
         end
         zhu_pkg::CMD_TOGGLE: begin
            ctrl_in.use_a = kind_ok;
            if (kind_ok) begin
               addr_a = zhu_pkg::piece_addr(req_color, req_piece_kind, req_from_square);
            end
         end
         zhu_pkg::CMD_MOVE: begin
            ctrl_in.use_a = kind_ok;
            ctrl_in.use_b = kind_ok;
            if (kind_ok) begin
               addr_a = zhu_pkg::piece_addr(req_color, req_piece_kind, req_from_square);
               addr_b = zhu_pkg::piece_addr(req_color, req_piece_kind, req_to_square);
            end
         end
         zhu_pkg::CMD_FLIP_SIDE: begin
            ctrl_in.use_b = 1'b1;
            addr_b        = zhu_pkg::SIDE_KEY;
         end
         zhu_pkg::CMD_CASTLING: begin
            ctrl_in.use_b = 1'b1;
            addr_b        = zhu_pkg::CASTLE_BASE
                          + zhu_pkg::key_addr_type'(req_castling_word);
         end
         zhu_pkg::CMD_EP_FILE: begin
            ctrl_in.use_b = 1'b1;
            addr_b        = zhu_pkg::EP_BASE + zhu_pkg::key_addr_type'(req_ep_file);
         end
         default: begin
            // unused codes leave the hash alone
         end
      endcase
   end

   // read stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   // key rom, two registered read ports, plus the carried payload
   always_ff @(posedge clock) begin
      if (advance) begin
         key_a_ff   <= zhu_pkg::KEY_TABLE[addr_a];
         key_b_ff   <= zhu_pkg::KEY_TABLE[addr_b];
         s1_ctrl_ff <= ctrl_in;
         load_ff    <= req_load_value;
      end
   end

   // next hash: a load replaces, anything else xors the selected keys
   always_comb begin
      if (s1_ctrl_ff.load) begin
         hash_in = load_ff;
      end else begin
         hash_in = hash_ff
                 ^ (s1_ctrl_ff.use_a ? key_a_ff : '0)
                 ^ (s1_ctrl_ff.use_b ? key_b_ff : '0);
      end
   end

   // hash state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            hash_ff <= hash_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_hash_ff <= hash_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hash  = rsp_hash_ff;

endmodule

/* hdl/zhu_checker.sv */
// port-level checks for the zobrist hash updater, bound to the top level
`include "assert_macros.svh"

module zhu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [2:0]  req_command,
   input logic [63:0] req_load_value,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_hash
);

   logic load_taken;

   assign load_taken = req_valid && !req_stall && req_command == zhu_pkg::CMD_LOAD;

   `ASSERT_NEXT(a_rsp_valid_holds, rsp_valid && rsp_stall, rsp_valid)
   `ASSERT_NEXT(a_rsp_hash_holds, rsp_valid && rsp_stall, $stable(rsp_hash))
   `ASSERT_SAME(a_stall_only_when_full, req_stall, rsp_valid && rsp_stall)
   `ASSERT_NEXT(a_load_reaches_rsp, load_taken ##1 !req_stall,
                rsp_valid && rsp_hash == $past(req_load_value, 2))

endmodule

bind zobrist_hash_updater_core zhu_checker u_zhu_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_command    (req_command),
   .req_load_value (req_load_value),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_hash       (rsp_hash)
);

/* dv/zobrist_hash_updater_core_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench of the zobrist hash updater core: directed and random command words
module zobrist_hash_updater_core_tb;

   // run size and safety limits
   localparam int RANDOM_WORDS = 2000;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int TAIL_CYCLES  = 10;
   localparam int REPORT_CAP   = 40;

   // command codes the block leaves without effect
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;

   // receiver stall behaviour, one mode per stretch of cycles
   localparam int STALL_NONE   = 0;
   localparam int STALL_TOGGLE = 1;
   localparam int STALL_LIGHT  = 2;
   localparam int STALL_HEAVY  = 3;

   // one command word as driven onto the req channel
   typedef struct {
      logic [2:0]  command;
      logic        color;
      logic [2:0]  piece_kind;
      logic [5:0]  from_square;
      logic [5:0]  to_square;
      logic [3:0]  castling_word;
      logic [2:0]  ep_file;
      logic [63:0] load_value;
      bit          drain_first;   // hold off until every hash has come back
   } hash_cmd_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_command;
   logic        req_color;
   logic [2:0]  req_piece_kind;
   logic [5:0]  req_from_square;
   logic [5:0]  req_to_square;
   logic [3:0]  req_castling_word;
   logic [2:0]  req_ep_file;
   logic [63:0] req_load_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_hash;

   // own copy of the key table and of the running hash
   zhu_pkg::hash_type zobrist_keys [0:zhu_pkg::KEY_COUNT-1];
   zhu_pkg::hash_type position_hash = '0;
   zhu_pkg::hash_type hash_expected_q [$];
   hash_cmd_type      command_q [$];
   hash_cmd_type      word_on_bus;

   logic word_taken = 1'b0;
   int   cycle_count = 0;
   int   error_count = 0;
   int   hashes_checked = 0;
   int   drain_pauses = 0;
   int   burst_left = 1;
   int   gap_left = 0;
   int   stall_mode = STALL_NONE;
   int   stall_left = 0;
   int   cmd_seen [0:7];

   zobrist_hash_updater_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_color         (req_color),
      .req_piece_kind    (req_piece_kind),
      .req_from_square   (req_from_square),
      .req_to_square     (req_to_square),
      .req_castling_word (req_castling_word),
      .req_ep_file       (req_ep_file),
      .req_load_value    (req_load_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hash          (rsp_hash)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // xorshift64* sequence, word k taken after k+1 steps from the seed
   initial begin
      zhu_pkg::hash_type s;
      s = zhu_pkg::GEN_SEED;
      for (int k = 0; k < zhu_pkg::KEY_COUNT; k++) begin
         s = s ^ (s >> zhu_pkg::SH_A);
         s = s ^ (s << zhu_pkg::SH_B);
         s = s ^ (s >> zhu_pkg::SH_C);
         zobrist_keys[k] = s * zhu_pkg::GEN_MUL;
      end
      for (int c = 0; c < 8; c++) cmd_seen[c] = 0;
   end

   // piece keys sit at color * 384 + kind * 64 + square
   function automatic int piece_slot(logic color, logic [2:0] kind, logic [5:0] square);
      return int'(color) * 384 + int'(kind) * 64 + int'(square);
   endfunction

   // hash after one command word; spare codes and bad piece kinds change nothing
   function automatic zhu_pkg::hash_type apply_command(zhu_pkg::hash_type cur,
                                                       hash_cmd_type w);
      zhu_pkg::hash_type nxt;
      nxt = cur;
      case (w.command)
         zhu_pkg::CMD_LOAD:
            nxt = w.load_value;
         zhu_pkg::CMD_TOGGLE:
            if (w.piece_kind < zhu_pkg::PIECE_KIND_COUNT)
               nxt = cur ^ zobrist_keys[piece_slot(w.color, w.piece_kind, w.from_square)];
         zhu_pkg::CMD_MOVE:
            // same square on both ends cancels out
            if (w.piece_kind < zhu_pkg::PIECE_KIND_COUNT)
               nxt = cur ^ zobrist_keys[piece_slot(w.color, w.piece_kind, w.from_square)]
                         ^ zobrist_keys[piece_slot(w.color, w.piece_kind, w.to_square)];
         zhu_pkg::CMD_FLIP_SIDE:
            nxt = cur ^ zobrist_keys[zhu_pkg::SIDE_KEY];
         zhu_pkg::CMD_CASTLING:
            nxt = cur ^ zobrist_keys[int'(zhu_pkg::CASTLE_BASE) + int'(w.castling_word)];
         zhu_pkg::CMD_EP_FILE:
            nxt = cur ^ zobrist_keys[int'(zhu_pkg::EP_BASE) + int'(w.ep_file)];
         default: ;
      endcase
      return nxt;
   endfunction

   function automatic hash_cmd_type make_word(logic [2:0] cmd, logic color, logic [2:0] kind,
                                              logic [5:0] from_sq, logic [5:0] to_sq,
                                              logic [3:0] cw, logic [2:0] ep,
                                              logic [63:0] load);
      hash_cmd_type w;
      w.command       = cmd;
      w.color         = color;
      w.piece_kind    = kind;
      w.from_square   = from_sq;
      w.to_square     = to_sq;
      w.castling_word = cw;
      w.ep_file       = ep;
      w.load_value    = load;
      w.drain_first   = 1'b0;
      return w;
   endfunction

   // game-like mix: mostly moves and toggles of real pieces, a little noise
   function automatic hash_cmd_type random_word();
      hash_cmd_type w;
      int           pick;
      pick = $urandom_range(0, 99);
      if (pick < 5)       w.command = zhu_pkg::CMD_LOAD;
      else if (pick < 30) w.command = zhu_pkg::CMD_TOGGLE;
      else if (pick < 65) w.command = zhu_pkg::CMD_MOVE;
      else if (pick < 80) w.command = zhu_pkg::CMD_FLIP_SIDE;
      else if (pick < 88) w.command = zhu_pkg::CMD_CASTLING;
      else if (pick < 96) w.command = zhu_pkg::CMD_EP_FILE;
      else if (pick < 98) w.command = CMD_SPARE_6;
      else                w.command = CMD_SPARE_7;
      w.color         = 1'($urandom_range(0, 1));
      w.piece_kind    = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                    : 3'($urandom_range(0, 5));
      w.from_square   = 6'($urandom_range(0, 63));
      w.to_square     = ($urandom_range(0, 19) == 0) ? w.from_square
                                                     : 6'($urandom_range(0, 63));
      w.castling_word = 4'($urandom_range(0, 15));
      w.ep_file       = 3'($urandom_range(0, 7));
      w.load_value    = {$urandom, $urandom};
      w.drain_first   = ($urandom_range(0, 199) == 0);
      return w;
   endfunction

   // stimulus list, reset and end of run
   initial begin
      hash_cmd_type w;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_command       = zhu_pkg::CMD_LOAD;
      req_color         = 1'b0;
      req_piece_kind    = '0;
      req_from_square   = '0;
      req_to_square     = '0;
      req_castling_word = '0;
      req_ep_file       = '0;
      req_load_value    = '0;
      rsp_stall         = 1'b0;

      // directed words: field extremes, every command, the corner cases
      command_q.push_back(make_word(zhu_pkg::CMD_LOAD, 0, 0, 0, 0, 0, 0, '0));
      command_q.push_back(make_word(zhu_pkg::CMD_TOGGLE, 0, 0, 0, 0, 0, 0, '0));
      command_q.push_back(make_word(zhu_pkg::CMD_TOGGLE, 1, 5, 63, 0, 0, 0, '0));
      command_q.push_back(make_word(zhu_pkg::CMD_MOVE, 0, 3, 12, 28, 0, 0, '0));
      command_q.push_back(make_word(zhu_pkg::CMD_MOVE, 1, 2, 63, 0, 0, 0, '0));
      // move onto its own square
      command_q.push_back(make_word(zhu_pkg::CMD_MOVE, 0, 4, 20, 20, 0, 0, '0));
      // piece kinds past the last real one
      command_q.push_back(make_word(zhu_pkg::CMD_TOGGLE, 1, 6, 7, 9, 0, 0, '0));
      command_q.push_back(make_word(zhu_pkg::CMD_MOVE, 0, 7, 1, 62, 0, 0, '0));
      command_q.push_back(make_word(zhu_pkg::CMD_FLIP_SIDE, 0, 0, 0, 0, 0, 0, '0));
      command_q.push_back(make_word(zhu_pkg::CMD_FLIP_SIDE, 1, 7, 63, 63, 15, 7, '1));
      command_q.push_back(make_word(zhu_pkg::CMD_CASTLING, 0, 0, 0, 0, 0, 0, '0));
      command_q.push_back(make_word(zhu_pkg::CMD_CASTLING, 0, 0, 0, 0, 15, 0, '0));
      command_q.push_back(make_word(zhu_pkg::CMD_EP_FILE, 0, 0, 0, 0, 0, 0, '0));
      command_q.push_back(make_word(zhu_pkg::CMD_EP_FILE, 0, 0, 0, 0, 0, 7, '0));
      // spare codes with every other field driven hard
      command_q.push_back(make_word(CMD_SPARE_6, 1, 5, 63, 63, 15, 7, '1));
      command_q.push_back(make_word(CMD_SPARE_7, 1, 5, 63, 63, 15, 7, '1));
      command_q.push_back(make_word(zhu_pkg::CMD_LOAD, 0, 0, 0, 0, 0, 0, '1));
      command_q.push_back(make_word(zhu_pkg::CMD_TOGGLE, 1, 5, 63, 63, 15, 7, '1));
      command_q.push_back(make_word(zhu_pkg::CMD_LOAD, 0, 0, 0, 0, 0, 0,
                                    64'hAAAA_AAAA_AAAA_AAAA));
      command_q.push_back(make_word(zhu_pkg::CMD_LOAD, 0, 0, 0, 0, 0, 0,
                                    64'h5555_5555_5555_5555));
      command_q.push_back(make_word(zhu_pkg::CMD_MOVE, 1, 0, 0, 63, 15, 7, '1));

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         w = random_word();
         // settle fully after the directed part and once mid run
         if (n == 0 || n == RANDOM_WORDS / 2) w.drain_first = 1'b1;
         command_q.push_back(w);
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (command_q.size() != 0 || req_valid) @(posedge clock);
      while (hash_expected_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d words: load %0d, toggle %0d, move %0d, flip %0d, castling %0d,",
               hashes_checked, cmd_seen[zhu_pkg::CMD_LOAD], cmd_seen[zhu_pkg::CMD_TOGGLE],
               cmd_seen[zhu_pkg::CMD_MOVE], cmd_seen[zhu_pkg::CMD_FLIP_SIDE],
               cmd_seen[zhu_pkg::CMD_CASTLING]);
      $display("  ep %0d, spare codes %0d, with %0d full drains and %0d mismatches",
               cmd_seen[zhu_pkg::CMD_EP_FILE], cmd_seen[CMD_SPARE_6] + cmd_seen[CMD_SPARE_7],
               drain_pauses, error_count);
      if (error_count == 0 && hash_expected_q.size() == 0) begin
         $display("[zobrist_hash_updater_core] OK");
      end else begin
         $display("[zobrist_hash_updater_core] ERROR");
      end
      $finish;
   end

   // sender: bursts of words with gaps, payload held while stalled
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !word_taken) begin
            // word still waiting, keep everything as it is
         end else if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left--;
         end else if (command_q.size() == 0) begin
            req_valid <= 1'b0;
         end else if (command_q[0].drain_first && hash_expected_q.size() != 0) begin
            // pause until the receiver has every hash
            req_valid <= 1'b0;
         end else begin
            if (command_q[0].drain_first) drain_pauses++;
            word_on_bus       = command_q.pop_front();
            req_command       <= word_on_bus.command;
            req_color         <= word_on_bus.color;
            req_piece_kind    <= word_on_bus.piece_kind;
            req_from_square   <= word_on_bus.from_square;
            req_to_square     <= word_on_bus.to_square;
            req_castling_word <= word_on_bus.castling_word;
            req_ep_file       <= word_on_bus.ep_file;
            req_load_value    <= word_on_bus.load_value;
            req_valid         <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               // a zero gap joins two bursts into one long stretch
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // receiver: stall pattern whose mode is drawn anew each time its stretch runs out
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
         stall_left = $urandom_range(16, 96);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_TOGGLE: rsp_stall <= cycle_count[0];
         STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 3) == 0);
         default:      rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // acceptance, prediction and comparison, all on the rising edge
   always @(posedge clock) begin
      zhu_pkg::hash_type exp_hash;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d hashes outstanding",
                  $realtime, cycle_count, hash_expected_q.size());
         $display("[zobrist_hash_updater_core] ERROR");
         $finish;
      end else begin
         word_taken <= !reset && req_valid && !req_stall;
         if (!reset) begin
            if (req_valid && !req_stall) begin
               position_hash = apply_command(position_hash, word_on_bus);
               hash_expected_q.push_back(position_hash);
               cmd_seen[word_on_bus.command]++;
            end
            if (rsp_valid && !rsp_stall) begin
               if (hash_expected_q.size() == 0) begin
                  error_count++;
                  if (error_count <= REPORT_CAP)
                     $display("%0t: hash word with none expected, expected none, actual %h",
                              $realtime, rsp_hash);
               end else begin
                  exp_hash = hash_expected_q.pop_front();
                  hashes_checked++;
                  if (rsp_hash !== exp_hash) begin
                     error_count++;
                     if (error_count <= REPORT_CAP)
                        $display("%0t: hash mismatch, expected %h, actual %h",
                                 $realtime, exp_hash, rsp_hash);
                  end
               end
            end
         end
      end
   end

endmodule
